### rtl/core/two_axis_trapezoid_profile_core_assert.svh
// Assertion macros shared by the profile core and its serial arithmetic unit.
`ifndef TWO_AXIS_TRAPEZOID_PROFILE_CORE_ASSERT_SVH
`define TWO_AXIS_TRAPEZOID_PROFILE_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define TATP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition in one cycle implies a condition in the next.
`define TATP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tatp_pkg.sv
package tatp_pkg;

  localparam logic [63:0] Usec     = 64'd1000000;
  localparam logic [63:0] UsecSq   = 64'd1000000000000;
  localparam logic [63:0] UsecSq2  = 64'd2000000000000;

  localparam logic [5:0] MulLast  = 6'd31;
  localparam logic [5:0] DivLast  = 6'd63;
  localparam logic [5:0] SqrtLast = 6'd31;

  localparam logic [1:0] RegMaxSpeed = 2'd0;
  localparam logic [1:0] RegAccel    = 2'd1;
  localparam logic [1:0] RegTick     = 2'd2;

  typedef enum logic [1:0] {
    ACT_PLAN   = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_CANCEL = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PL_DA,
    ST_PL_VV,
    ST_TR_MUL,
    ST_TR_DIV,
    ST_TR_SQRT,
    ST_TP_RM,
    ST_TP_RD,
    ST_TP_SD,
    ST_TP_CM,
    ST_TP_CD,
    ST_PL_FIN,
    ST_TK_M1,
    ST_TK_M2,
    ST_TK_D,
    ST_TK_VM,
    ST_TK_VD,
    ST_FA_M,
    ST_FA_D,
    ST_FB_M,
    ST_FB_D,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

  function automatic logic [31:0] sat_time(input logic [63:0] v);
    logic [31:0] r;
    r = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    return r;
  endfunction

endpackage

### rtl/core/tatp_serial_unit.sv
// Bit-serial multiply (mod 2^64), restoring divide and integer square root.
module tatp_serial_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tatp_pkg::unit_req_t req_i,
  input  logic [63:0]         opa_i,
  input  logic [63:0]         opb_i,
  output tatp_pkg::unit_rsp_t rsp_o,
  output logic [63:0]         res_o
);

  logic            busy_q, busy_d, done_q, done_d;
  logic [5:0]      cnt_q, cnt_d;
  tatp_pkg::op_e   op_q, op_d;
  logic [63:0]     acc_q, acc_d, x_q, x_d, y_q, y_d;
  logic [63:0]     rem_div, rem_sq, trial;

  assign rem_div = {acc_q[62:0], x_q[63]};
  assign rem_sq  = {acc_q[61:0], y_q[63:62]};
  assign trial   = {x_q[61:0], 2'b01};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      acc_d  = 64'd0;
      case (req_i.op)
        tatp_pkg::OP_MUL: begin
          x_d   = opa_i;
          y_d   = opb_i;
          cnt_d = tatp_pkg::MulLast;
        end
        tatp_pkg::OP_DIV: begin
          x_d   = opa_i;
          y_d   = opb_i;
          cnt_d = tatp_pkg::DivLast;
        end
        default: begin
          x_d   = 64'd0;
          y_d   = opa_i;
          cnt_d = tatp_pkg::SqrtLast;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        tatp_pkg::OP_MUL: begin
          acc_d = {acc_q[62:0], 1'b0} + (y_q[31] ? x_q : 64'd0);
          y_d   = {y_q[62:0], 1'b0};
        end
        tatp_pkg::OP_DIV: begin
          if (rem_div >= y_q) begin
            acc_d = rem_div - y_q;
            x_d   = {x_q[62:0], 1'b1};
          end else begin
            acc_d = rem_div;
            x_d   = {x_q[62:0], 1'b0};
          end
        end
        default: begin
          y_d = {y_q[61:0], 2'b00};
          if (rem_sq >= trial) begin
            acc_d = rem_sq - trial;
            x_d   = {x_q[62:0], 1'b1};
          end else begin
            acc_d = rem_sq;
            x_d   = {x_q[62:0], 1'b0};
          end
        end
      endcase
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
      op_q   <= tatp_pkg::OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign res_o      = (op_q == tatp_pkg::OP_MUL) ? acc_q : x_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;

  `include "two_axis_trapezoid_profile_core_assert.svh"

  `TATP_ASSERT(a_start_idle, req_i.start |-> !busy_q, "unit started while busy")
  `TATP_ASSERT(a_done_after_busy, done_q |-> $past(busy_q), "done without a running op")
  `TATP_ASSERT_NEXT(a_last_step_done, busy_q && cnt_q == 6'd0, done_q, "last step gave no done")

endmodule

### rtl/core/two_axis_trapezoid_profile_core.sv
// Two-axis trapezoidal move generator.
// Input stream (s_axis_*): one transfer per command. tuser carries the action
// (plan, tick, cancel); tdata carries start and target angles for a plan.
// Output stream (m_axis_*): exactly one result transfer per command, with the
// commanded angles in tdata and the status flags in tuser.
// Configuration: cfg_we_i writes register cfg_idx_i (speed, acceleration,
// tick period) on the clock edge; write only while the block is idle.
// All arithmetic goes through one bit-serial unit, one operation at a time.
// A cancel, an idle tick, an arrival and a move too small to plan go straight to
// the output state; a plan runs a triangular or a trapezoidal sequence and an
// in-progress tick a cruise or a ramp sequence (up to four products and three
// quotients). One command is in flight at a time; s_axis_tready_o is high only
// while the sequencer is idle, so it rises in the same cycle that the result
// register becomes valid.
// The finished result sits in an output register; if the receiver stalls the
// sequencer holds in its output state until the register frees.
// Reset clears the move and the output valid flag and loads the default speed,
// acceleration and tick period.
module two_axis_trapezoid_profile_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [87:0] s_axis_tdata_i,  // start_a, start_b, target_a, target_b, zero pad
  input  logic [1:0]  s_axis_tuser_i,  // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // angle_a, angle_b, zero pad
  output logic [2:0]  m_axis_tuser_o,  // valid_res, arrived, moving
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [25:0] cfg_data_i
);

  // Configuration
  logic [21:0] speed_q;
  logic [25:0] accel_q;
  logic [15:0] tick_q;
  logic [21:0] speed_eff;
  logic [25:0] accel_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= 22'd92160;
      accel_q <= 26'd184320;
      tick_q  <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tatp_pkg::RegMaxSpeed: speed_q <= cfg_data_i[21:0];
        tatp_pkg::RegAccel:    accel_q <= cfg_data_i;
        tatp_pkg::RegTick:     tick_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Treat a zero speed or acceleration as one
  assign speed_eff = (speed_q == 22'd0) ? 22'd1 : speed_q;
  assign accel_eff = (accel_q == 26'd0) ? 26'd1 : accel_q;

  // Move state
  tatp_pkg::st_e st_q, st_d;
  logic        launched_q, launched_d;
  logic        active_q, active_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [20:0] origin_a_q, origin_a_d, origin_b_q, origin_b_d;
  logic [21:0] span_a_q, span_a_d, span_b_q, span_b_d;
  logic [20:0] dspan_q, dspan_d;
  logic [31:0] ramp_q, ramp_d, cruise_q, cruise_d, total_q, total_d;
  logic [20:0] rspan_q, rspan_d;
  logic [63:0] vv_q, vv_d, tmp_q, tmp_d;
  logic [31:0] u_q, u_d;
  logic        dec_q, dec_d;
  logic [20:0] p_q, p_d;
  logic [20:0] pend_a_q, pend_a_d, pend_b_q, pend_b_d;
  logic [2:0]  pend_fl_q, pend_fl_d;
  logic        out_vld_q, out_vld_d;
  logic [20:0] out_a_q, out_a_d, out_b_q, out_b_d;
  logic [2:0]  out_fl_q, out_fl_d;

  // Serial unit
  tatp_pkg::unit_req_t unit_req;
  tatp_pkg::unit_rsp_t unit_rsp;
  logic [63:0]         opa, opb, unit_res;

  tatp_serial_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .opa_i  (opa),
    .opb_i  (opb),
    .rsp_o  (unit_rsp),
    .res_o  (unit_res)
  );

  // Input decode
  logic [20:0] in_sa, in_sb, in_ta, in_tb;
  logic [21:0] sp_a, sp_b, mag_a, mag_b, mag_sa, mag_sb, dmax;
  logic        in_acc;

  assign in_sa  = s_axis_tdata_i[20:0];
  assign in_sb  = s_axis_tdata_i[41:21];
  assign in_ta  = s_axis_tdata_i[62:42];
  assign in_tb  = s_axis_tdata_i[83:63];
  assign sp_a   = {in_ta[20], in_ta} - {in_sa[20], in_sa};
  assign sp_b   = {in_tb[20], in_tb} - {in_sb[20], in_sb};
  assign mag_a  = sp_a[21] ? (~sp_a + 22'd1) : sp_a;
  assign mag_b  = sp_b[21] ? (~sp_b + 22'd1) : sp_b;
  assign dmax   = (mag_a > mag_b) ? mag_a : mag_b;
  assign mag_sa = span_a_q[21] ? (~span_a_q + 22'd1) : span_a_q;
  assign mag_sb = span_b_q[21] ? (~span_b_q + 22'd1) : span_b_q;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (st_q == tatp_pkg::ST_IDLE);

  // Sequencer
  always_comb begin
    logic [63:0] pick;
    logic [32:0] rc_sum;
    logic [31:0] rem_t;
    logic [22:0] ang;
    logic [22:0] org;
    logic [32:0] el_sum;
    logic [33:0] tot_sum;

    st_d       = st_q;
    launched_d = launched_q;
    active_d   = active_q;
    elapsed_d  = elapsed_q;
    origin_a_d = origin_a_q;
    origin_b_d = origin_b_q;
    span_a_d   = span_a_q;
    span_b_d   = span_b_q;
    dspan_d    = dspan_q;
    ramp_d     = ramp_q;
    cruise_d   = cruise_q;
    total_d    = total_q;
    rspan_d    = rspan_q;
    vv_d       = vv_q;
    tmp_d      = tmp_q;
    u_d        = u_q;
    dec_d      = dec_q;
    p_d        = p_q;
    pend_a_d   = pend_a_q;
    pend_b_d   = pend_b_q;
    pend_fl_d  = pend_fl_q;
    out_vld_d  = out_vld_q;
    out_a_d    = out_a_q;
    out_b_d    = out_b_q;
    out_fl_d   = out_fl_q;
    unit_req.start = 1'b0;
    unit_req.op    = tatp_pkg::OP_MUL;
    opa        = 64'd0;
    opb        = 64'd0;
    pick       = 64'd0;
    rc_sum     = {1'b0, ramp_q} + {1'b0, cruise_q};
    rem_t      = total_q - elapsed_q;
    ang        = 23'd0;
    org        = 23'd0;
    el_sum     = {1'b0, elapsed_q} + {17'd0, tick_q};
    tot_sum    = {1'b0, ramp_q, 1'b0} + {2'b00, cruise_q};

    // Drop the result once the receiver takes it
    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (st_q)
      tatp_pkg::ST_IDLE: begin
        if (in_acc) begin
          pend_a_d  = 21'd0;
          pend_b_d  = 21'd0;
          pend_fl_d = 3'b000;
          st_d      = tatp_pkg::ST_OUT;
          case (s_axis_tuser_i)
            tatp_pkg::ACT_PLAN: begin
              active_d   = 1'b0;
              elapsed_d  = 32'd0;
              origin_a_d = in_sa;
              origin_b_d = in_sb;
              span_a_d   = sp_a;
              span_b_d   = sp_b;
              dspan_d    = dmax[20:0];
              pend_a_d   = in_sa;
              pend_b_d   = in_sb;
              // Under 0.001 degree: stay idle
              if (dmax >= 22'd2) begin
                st_d = tatp_pkg::ST_PL_DA;
              end
            end
            tatp_pkg::ACT_TICK: begin
              if (active_q) begin
                if (elapsed_q >= total_q) begin
                  pend_a_d  = 21'({origin_a_q[20], origin_a_q} + span_a_q);
                  pend_b_d  = 21'({origin_b_q[20], origin_b_q} + span_b_q);
                  pend_fl_d = 3'b010;
                  active_d  = 1'b0;
                end else if (elapsed_q < ramp_q) begin
                  u_d   = elapsed_q;
                  dec_d = 1'b0;
                  st_d  = tatp_pkg::ST_TK_M1;
                end else if ({1'b0, elapsed_q} < rc_sum) begin
                  u_d  = elapsed_q - ramp_q;
                  st_d = tatp_pkg::ST_TK_VM;
                end else begin
                  u_d   = (rem_t > ramp_q) ? ramp_q : rem_t;
                  dec_d = 1'b1;
                  st_d  = tatp_pkg::ST_TK_M1;
                end
              end
            end
            tatp_pkg::ACT_CANCEL: begin
              active_d  = 1'b0;
              elapsed_d = 32'd0;
            end
            default: begin
              pend_fl_d = {active_q, 2'b00};
            end
          endcase
        end
      end

      tatp_pkg::ST_PL_FIN: begin
        total_d   = tatp_pkg::sat_time(64'(tot_sum));
        active_d  = 1'b1;
        pend_fl_d = 3'b100;
        st_d      = tatp_pkg::ST_OUT;
      end

      tatp_pkg::ST_OUT: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_a_d   = pend_a_q;
          out_b_d   = pend_b_q;
          out_fl_d  = pend_fl_q;
          st_d      = tatp_pkg::ST_IDLE;
        end
      end

      default: begin
        // Arithmetic steps: launch once, advance on completion
        case (st_q)
          tatp_pkg::ST_PL_DA: begin
            opa = 64'(dspan_q);
            opb = 64'(accel_eff);
          end
          tatp_pkg::ST_PL_VV: begin
            opa = 64'(speed_eff);
            opb = 64'(speed_eff);
          end
          tatp_pkg::ST_TR_MUL: begin
            opa = tatp_pkg::UsecSq;
            opb = 64'(dspan_q);
          end
          tatp_pkg::ST_TR_DIV: begin
            unit_req.op = tatp_pkg::OP_DIV;
            opa = tmp_q;
            opb = 64'(accel_eff);
          end
          tatp_pkg::ST_TR_SQRT: begin
            unit_req.op = tatp_pkg::OP_SQRT;
            opa = tmp_q;
          end
          tatp_pkg::ST_TP_RM: begin
            opa = tatp_pkg::Usec;
            opb = 64'(speed_eff);
          end
          tatp_pkg::ST_TP_RD: begin
            unit_req.op = tatp_pkg::OP_DIV;
            opa = tmp_q;
            opb = 64'(accel_eff);
          end
          tatp_pkg::ST_TP_SD: begin
            unit_req.op = tatp_pkg::OP_DIV;
            opa = vv_q;
            opb = {37'd0, accel_eff, 1'b0};
          end
          tatp_pkg::ST_TP_CM: begin
            opa = tatp_pkg::Usec;
            opb = 64'(dspan_q) - {42'd0, rspan_q, 1'b0};
          end
          tatp_pkg::ST_TP_CD: begin
            unit_req.op = tatp_pkg::OP_DIV;
            opa = tmp_q;
            opb = 64'(speed_eff);
          end
          tatp_pkg::ST_TK_M1: begin
            opa = 64'(accel_eff);
            opb = 64'(u_q);
          end
          tatp_pkg::ST_TK_M2: begin
            opa = tmp_q;
            opb = 64'(u_q);
          end
          tatp_pkg::ST_TK_D: begin
            unit_req.op = tatp_pkg::OP_DIV;
            opa = tmp_q;
            opb = tatp_pkg::UsecSq2;
          end
          tatp_pkg::ST_TK_VM: begin
            opa = 64'(speed_eff);
            opb = 64'(u_q);
          end
          tatp_pkg::ST_TK_VD: begin
            unit_req.op = tatp_pkg::OP_DIV;
            opa = tmp_q;
            opb = tatp_pkg::Usec;
          end
          tatp_pkg::ST_FA_M: begin
            opa = 64'(p_q);
            opb = 64'(mag_sa);
          end
          tatp_pkg::ST_FB_M: begin
            opa = 64'(p_q);
            opb = 64'(mag_sb);
          end
          tatp_pkg::ST_FA_D, tatp_pkg::ST_FB_D: begin
            unit_req.op = tatp_pkg::OP_DIV;
            opa = tmp_q;
            opb = 64'(dspan_q);
          end
          default: ;
        endcase

        if (!launched_q) begin
          unit_req.start = 1'b1;
          launched_d     = 1'b1;
        end

        if (unit_rsp.done) begin
          launched_d = 1'b0;
          case (st_q)
            tatp_pkg::ST_PL_DA: begin
              tmp_d = unit_res;
              st_d  = tatp_pkg::ST_PL_VV;
            end
            tatp_pkg::ST_PL_VV: begin
              vv_d = unit_res;
              st_d = (tmp_q <= unit_res) ? tatp_pkg::ST_TR_MUL : tatp_pkg::ST_TP_RM;
            end
            tatp_pkg::ST_TR_MUL: begin
              tmp_d = unit_res;
              st_d  = tatp_pkg::ST_TR_DIV;
            end
            tatp_pkg::ST_TR_DIV: begin
              tmp_d = unit_res;
              st_d  = tatp_pkg::ST_TR_SQRT;
            end
            tatp_pkg::ST_TR_SQRT: begin
              ramp_d   = tatp_pkg::sat_time(unit_res);
              cruise_d = 32'd0;
              rspan_d  = {1'b0, dspan_q[20:1]};
              st_d     = tatp_pkg::ST_PL_FIN;
            end
            tatp_pkg::ST_TP_RM: begin
              tmp_d = unit_res;
              st_d  = tatp_pkg::ST_TP_RD;
            end
            tatp_pkg::ST_TP_RD: begin
              ramp_d = tatp_pkg::sat_time(unit_res);
              st_d   = tatp_pkg::ST_TP_SD;
            end
            tatp_pkg::ST_TP_SD: begin
              rspan_d = unit_res[20:0];
              st_d    = tatp_pkg::ST_TP_CM;
            end
            tatp_pkg::ST_TP_CM: begin
              tmp_d = unit_res;
              st_d  = tatp_pkg::ST_TP_CD;
            end
            tatp_pkg::ST_TP_CD: begin
              cruise_d = tatp_pkg::sat_time(unit_res);
              st_d     = tatp_pkg::ST_PL_FIN;
            end
            tatp_pkg::ST_TK_M1: begin
              tmp_d = unit_res;
              st_d  = tatp_pkg::ST_TK_M2;
            end
            tatp_pkg::ST_TK_M2: begin
              tmp_d = unit_res;
              st_d  = tatp_pkg::ST_TK_D;
            end
            tatp_pkg::ST_TK_D, tatp_pkg::ST_TK_VD: begin
              if (st_q == tatp_pkg::ST_TK_VD) begin
                pick = 64'(rspan_q) + unit_res;
              end else if (dec_q) begin
                // Deceleration: span less the distance left to the target
                pick = (unit_res >= 64'(dspan_q)) ? 64'd0 : 64'(dspan_q) - unit_res;
              end else begin
                pick = unit_res;
              end
              p_d  = (pick > 64'(dspan_q)) ? dspan_q : pick[20:0];
              st_d = tatp_pkg::ST_FA_M;
            end
            tatp_pkg::ST_TK_VM: begin
              tmp_d = unit_res;
              st_d  = tatp_pkg::ST_TK_VD;
            end
            tatp_pkg::ST_FA_M: begin
              tmp_d = unit_res;
              st_d  = tatp_pkg::ST_FA_D;
            end
            tatp_pkg::ST_FA_D: begin
              org = {origin_a_q[20], origin_a_q[20], origin_a_q};
              ang = span_a_q[21] ? org - {1'b0, unit_res[21:0]}
                                 : org + {1'b0, unit_res[21:0]};
              pend_a_d = ang[20:0];
              st_d     = tatp_pkg::ST_FB_M;
            end
            tatp_pkg::ST_FB_M: begin
              tmp_d = unit_res;
              st_d  = tatp_pkg::ST_FB_D;
            end
            tatp_pkg::ST_FB_D: begin
              org = {origin_b_q[20], origin_b_q[20], origin_b_q};
              ang = span_b_q[21] ? org - {1'b0, unit_res[21:0]}
                                 : org + {1'b0, unit_res[21:0]};
              pend_b_d  = ang[20:0];
              pend_fl_d = 3'b101;
              // Advance motion time, saturating
              elapsed_d = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
              st_d      = tatp_pkg::ST_OUT;
            end
            default: st_d = tatp_pkg::ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= tatp_pkg::ST_IDLE;
      launched_q <= 1'b0;
      active_q   <= 1'b0;
      elapsed_q  <= 32'd0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      launched_q <= launched_d;
      active_q   <= active_d;
      elapsed_q  <= elapsed_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    origin_a_q <= origin_a_d;
    origin_b_q <= origin_b_d;
    span_a_q   <= span_a_d;
    span_b_q   <= span_b_d;
    dspan_q    <= dspan_d;
    ramp_q     <= ramp_d;
    cruise_q   <= cruise_d;
    total_q    <= total_d;
    rspan_q    <= rspan_d;
    vv_q       <= vv_d;
    tmp_q      <= tmp_d;
    u_q        <= u_d;
    dec_q      <= dec_d;
    p_q        <= p_d;
    pend_a_q   <= pend_a_d;
    pend_b_q   <= pend_b_d;
    pend_fl_q  <= pend_fl_d;
    out_a_q    <= out_a_d;
    out_b_q    <= out_b_d;
    out_fl_q   <= out_fl_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, out_b_q, out_a_q};
  assign m_axis_tuser_o  = out_fl_q;

  `include "two_axis_trapezoid_profile_core_assert.svh"

  `TATP_ASSERT(a_idle_unit_free, s_axis_tready_o |-> !unit_rsp.busy, "unit busy while idle")
  `TATP_ASSERT(a_done_launched, unit_rsp.done |-> launched_q, "unit result not requested")
  `TATP_ASSERT_NEXT(a_one_in_flight, in_acc, !s_axis_tready_o, "second command taken")

endmodule

### sim/two_axis_trapezoid_profile_core_tb.sv
module two_axis_trapezoid_profile_core_tb;

  typedef longint unsigned u64_t;
  typedef longint          s64_t;

  // Action code outside the enum; the block must ignore it.
  localparam logic [1:0] ActIgnored = 2'd3;
  localparam logic [20:0] AngMin = 21'h100000;
  localparam logic [20:0] AngMax = 21'h0FFFFF;
  localparam u64_t TimeCap = 64'hFFFF_FFFF;
  localparam u64_t OneSec = 64'd1000000;
  localparam u64_t OneSecSq = 64'd1000000000000;

  // One result transfer as the block presents it.
  typedef struct packed {
    logic [20:0] angle_a;
    logic [20:0] angle_b;
    logic        valid_res;
    logic        arrived;
    logic        moving;
  } point_t;

  // Software image of the profile generator: its own copy of the move state and
  // registers, and the queue of points that the block still owes.
  class profile_scoreboard;
    u64_t   speed_lim, accel_lim, tick_us;
    bit     in_motion;
    u64_t   elapsed, span_max, ramp_t, cruise_t, total_t, ramp_dist;
    s64_t   org_a, org_b, dlt_a, dlt_b;
    point_t owed[$];
    int     n_plans, n_arrivals, n_points;

    function new();
      speed_lim = 92160;
      accel_lim = 184320;
      tick_us   = 1000;
    endfunction

    function void set_reg(logic [1:0] idx, logic [25:0] val);
      case (idx)
        tatp_pkg::RegMaxSpeed: speed_lim = u64_t'(val[21:0]);
        tatp_pkg::RegAccel:    accel_lim = u64_t'(val);
        tatp_pkg::RegTick:     tick_us   = u64_t'(val[15:0]);
        default: ;
      endcase
    endfunction

    function u64_t clip_t(u64_t v);
      return (v > TimeCap) ? TimeCap : v;
    endfunction

    function u64_t root(u64_t x);
      u64_t r, b;
      r = 0;
      b = u64_t'(1) << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function u64_t absv(s64_t v);
      return (v < 0) ? u64_t'(-v) : u64_t'(v);
    endfunction

    function u64_t travel(u64_t t);
      u64_t a, v, p, d, rem;
      a = (accel_lim == 0) ? 1 : accel_lim;
      v = (speed_lim == 0) ? 1 : speed_lim;
      if (t < ramp_t) begin
        p = a * t * t / (2 * OneSecSq);
      end else if (t < ramp_t + cruise_t) begin
        p = ramp_dist + v * (t - ramp_t) / OneSec;
      end else begin
        rem = total_t - t;
        if (rem > ramp_t) rem = ramp_t;
        d = a * rem * rem / (2 * OneSecSq);
        p = (d >= span_max) ? 0 : span_max - d;
      end
      return (p > span_max) ? span_max : p;
    endfunction

    function logic [20:0] scale(s64_t org, s64_t dlt, u64_t p);
      u64_t off;
      s64_t r;
      off = absv(dlt) * p / span_max;
      r = (dlt < 0) ? org - s64_t'(off) : org + s64_t'(off);
      return r[20:0];
    endfunction

    // Note an accepted command and queue the point it must produce.
    function void note_command(logic [1:0] act, logic [87:0] pkt);
      point_t pt;
      s64_t   sa, sb, ta, tb;
      u64_t   a, v, d, p;
      pt = '0;
      case (act)
        tatp_pkg::ACT_PLAN: begin
          sa = s64_t'($signed(pkt[20:0]));
          sb = s64_t'($signed(pkt[41:21]));
          ta = s64_t'($signed(pkt[62:42]));
          tb = s64_t'($signed(pkt[83:63]));
          a = (accel_lim == 0) ? 1 : accel_lim;
          v = (speed_lim == 0) ? 1 : speed_lim;
          in_motion = 0;
          elapsed = 0; span_max = 0; ramp_t = 0; cruise_t = 0; total_t = 0; ramp_dist = 0;
          org_a = sa; org_b = sb;
          dlt_a = ta - sa; dlt_b = tb - sb;
          d = (absv(dlt_a) > absv(dlt_b)) ? absv(dlt_a) : absv(dlt_b);
          if (d * 1000 >= 1024) begin
            span_max = d;
            if (d * a <= v * v) begin
              // triangular: never reaches the speed limit
              ramp_t = clip_t(root(d * OneSecSq / a));
              cruise_t = 0;
              ramp_dist = d / 2;
            end else begin
              ramp_t = clip_t(v * OneSec / a);
              ramp_dist = v * v / (2 * a);
              cruise_t = clip_t((d - 2 * ramp_dist) * OneSec / v);
            end
            total_t = clip_t(2 * ramp_t + cruise_t);
            in_motion = 1;
          end
          pt.angle_a = sa[20:0];
          pt.angle_b = sb[20:0];
          pt.moving = in_motion;
          n_plans++;
        end
        tatp_pkg::ACT_TICK: begin
          if (in_motion) begin
            if (elapsed >= total_t) begin
              pt.angle_a = 21'(org_a + dlt_a);
              pt.angle_b = 21'(org_b + dlt_b);
              pt.arrived = 1;
              in_motion = 0;
              n_arrivals++;
            end else begin
              p = travel(elapsed);
              pt.angle_a = scale(org_a, dlt_a, p);
              pt.angle_b = scale(org_b, dlt_b, p);
              pt.valid_res = 1;
              pt.moving = 1;
              elapsed = clip_t(elapsed + tick_us);
              n_points++;
            end
          end
        end
        tatp_pkg::ACT_CANCEL: begin
          in_motion = 0;
          elapsed = 0;
        end
        default: pt.moving = in_motion;
      endcase
      owed.push_back(pt);
    endfunction

    // Compare a delivered point with the oldest owed one; empty string if it matches.
    function string check_point(point_t got);
      point_t want;
      string  msg;
      if (owed.size() == 0) return "point delivered with none owed";
      want = owed.pop_front();
      msg = "";
      if (got.angle_a !== want.angle_a)
        msg = {msg, $sformatf(" angle_a %0h/%0h", got.angle_a, want.angle_a)};
      if (got.angle_b !== want.angle_b)
        msg = {msg, $sformatf(" angle_b %0h/%0h", got.angle_b, want.angle_b)};
      if (got.valid_res !== want.valid_res) msg = {msg, " valid_res"};
      if (got.arrived !== want.arrived) msg = {msg, " arrived"};
      if (got.moving !== want.moving) msg = {msg, " moving"};
      return msg;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [87:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [25:0] cfg_data_i = '0;

  profile_scoreboard sb = new();
  int n_errors = 0;
  int n_results = 0;
  int n_sent = 0;
  int burst_left = 0;

  two_axis_trapezoid_profile_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #400000000;
    $display("two_axis_trapezoid_profile_core_tb: errors");
    $finish;
  end

  task automatic report(input string what);
    n_errors++;
    $display("mismatch at result %0d:%s", n_results, what);
  endtask

  // Receiver: sample at the edge, then choose tready for the next cycle. One long
  // hold-off lets the block fill and back up its input.
  initial begin : receiver
    logic [15:0] pattern;
    int          phase_bits;
    int          hold_off;
    bit          held;
    point_t      got;
    string       msg;
    pattern = '1;
    phase_bits = 0;
    hold_off = 0;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tdata_o[20:0], m_axis_tdata_o[41:21],
               m_axis_tuser_o[0], m_axis_tuser_o[1], m_axis_tuser_o[2]};
        msg = sb.check_point(got);
        if (msg != "") report(msg);
        n_results++;
      end
      if (!held && n_results == 400) begin
        held = 1;
        hold_off = 3000;
      end
      if (phase_bits == 0) begin
        // a third of the windows run without stalls
        pattern = ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom) | 16'h5111;
        phase_bits = 16;
      end
      phase_bits--;
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= pattern[phase_bits];
      end
    end
  end

  // Offer one command and hold it until accepted; gaps fall between bursts.
  task automatic send_cmd(input logic [1:0] act, input logic [87:0] pkt);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= act;
    s_axis_tdata_i <= pkt;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(act, pkt);
    n_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [87:0] pack_move(logic [20:0] sa, logic [20:0] sbv,
                                            logic [20:0] ta, logic [20:0] tb);
    return {4'd0, tb, ta, sbv, sa};
  endfunction

  // Let the block drain, then write one register.
  task automatic write_reg(input logic [1:0] idx, input logic [25:0] val);
    s_axis_tvalid_i <= 1'b0;
    wait (sb.owed.size() == 0);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [87:0] random_move();
    logic [20:0] sa, sbv, ta, tb;
    int          pick;
    sa = 21'($urandom);
    sbv = 21'($urandom);
    pick = $urandom_range(19);
    if (pick < 2) begin
      // full range, usually far beyond what finishes
      ta = 21'($urandom);
      tb = 21'($urandom);
    end else if (pick < 4) begin
      // below the minimum move on both axes
      ta = sa + 21'($urandom_range(1));
      tb = sbv - 21'($urandom_range(1));
    end else begin
      ta = sa + 21'($signed(13'($urandom)));
      tb = ($urandom_range(4) == 0) ? sbv + (ta - sa) : sbv + 21'($signed(12'($urandom)));
    end
    return pack_move(sa, sbv, ta, tb);
  endfunction

  // Well-formed motion most of the time: plan, tick on, sometimes cancel or replan.
  task automatic random_phase(input int n);
    int k, r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (!sb.in_motion) begin
        if (r < 75) send_cmd(tatp_pkg::ACT_PLAN, random_move());
        else if (r < 85) send_cmd(tatp_pkg::ACT_TICK, 88'($urandom));
        else if (r < 93) send_cmd(tatp_pkg::ACT_CANCEL, 88'($urandom));
        else send_cmd(ActIgnored, 88'($urandom));
      end else begin
        if (r < 85) send_cmd(tatp_pkg::ACT_TICK, 88'($urandom));
        else if (r < 91) send_cmd(tatp_pkg::ACT_PLAN, random_move());
        else if (r < 95) send_cmd(tatp_pkg::ACT_CANCEL, 88'($urandom));
        else send_cmd(ActIgnored, 88'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle commands, the extreme spans, ties, the too-small move.
    send_cmd(tatp_pkg::ACT_TICK, '0);
    send_cmd(tatp_pkg::ACT_CANCEL, '0);
    send_cmd(ActIgnored, '1);
    send_cmd(tatp_pkg::ACT_PLAN, pack_move(AngMin, AngMax, AngMax, AngMin));
    send_cmd(ActIgnored, '0);
    send_cmd(tatp_pkg::ACT_TICK, '0);
    send_cmd(tatp_pkg::ACT_TICK, '0);
    send_cmd(tatp_pkg::ACT_PLAN, pack_move(AngMax, AngMin, AngMin, AngMax));
    send_cmd(tatp_pkg::ACT_TICK, '0);
    send_cmd(tatp_pkg::ACT_CANCEL, '0);
    send_cmd(tatp_pkg::ACT_TICK, '0);
    send_cmd(tatp_pkg::ACT_PLAN, pack_move(21'd0, 21'd0, 21'd1, 21'h1FFFFF));
    send_cmd(tatp_pkg::ACT_TICK, '0);
    send_cmd(tatp_pkg::ACT_PLAN, pack_move(21'd5, 21'd5, 21'd5, 21'd5));
    send_cmd(tatp_pkg::ACT_PLAN, pack_move(21'd100, 21'd0, 21'd1124, 21'h1FFC00));
    send_cmd(tatp_pkg::ACT_TICK, '0);
    send_cmd(tatp_pkg::ACT_TICK, '0);
    send_cmd(tatp_pkg::ACT_CANCEL, '0);

    // Very fast profile: a move ends within a few ticks, so arrival shows up.
    write_reg(tatp_pkg::RegMaxSpeed, 26'h3FFFFF);
    write_reg(tatp_pkg::RegAccel, 26'h3FFFFFF);
    write_reg(tatp_pkg::RegTick, 26'hFFFF);
    send_cmd(tatp_pkg::ACT_PLAN, pack_move(21'd0, 21'd0, 21'd3000, 21'h1FF000));
    for (k = 0; k < 6; k++) send_cmd(tatp_pkg::ACT_TICK, '0);
    random_phase(350);

    // Slowest extreme: everything at its minimum.
    write_reg(tatp_pkg::RegMaxSpeed, 26'd1);
    write_reg(tatp_pkg::RegAccel, 26'd1);
    write_reg(tatp_pkg::RegTick, 26'd1);
    random_phase(200);

    write_reg(tatp_pkg::RegMaxSpeed, 26'd92160);
    write_reg(tatp_pkg::RegAccel, 26'd184320);
    write_reg(tatp_pkg::RegTick, 26'd20000);
    random_phase(400);

    for (k = 0; k < 3; k++) begin
      write_reg(tatp_pkg::RegMaxSpeed, 26'($urandom_range(1000, 4194303)));
      write_reg(tatp_pkg::RegAccel, 26'($urandom_range(1000, 67108863)));
      write_reg(tatp_pkg::RegTick, 26'($urandom_range(2000, 65535)));
      random_phase(300);
    end

    s_axis_tvalid_i <= 1'b0;
    wait (sb.owed.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("covered %0d commands, %0d results: %0d plans, %0d in-move points, %0d arrivals",
             n_sent, n_results, sb.n_plans, sb.n_points, sb.n_arrivals);
    $display("register settings swept from minimum to maximum speed, acceleration and tick");
    if (n_errors == 0) begin
      $display("two_axis_trapezoid_profile_core_tb: clean");
    end else begin
      $display("two_axis_trapezoid_profile_core_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/tatp_pkg.sv
rtl/core/tatp_serial_unit.sv
rtl/core/two_axis_trapezoid_profile_core.sv
sim/two_axis_trapezoid_profile_core_tb.sv
